// ----- hdl/audio_delay_line_crossfade_core_assert.svh -----
// Assertion macros used by the checker module of the delay line core.
`ifndef AUDIO_DELAY_LINE_CROSSFADE_CORE_ASSERT_SVH
`define AUDIO_DELAY_LINE_CROSSFADE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADLC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adlc: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adlc: assertion failed");

`endif

// ----- hdl/adlc_pkg.sv -----
// Shared constants, types and codes of the delay line crossfade core.
`default_nettype none

package adlc_pkg;

   // Default sizes of the delay memory and of one sample.
   localparam int DELAY_DEPTH_DEF = 16384;
   localparam int SAMPLE_BITS_DEF = 24;

   // Fixed register and counter widths.
   localparam int DLY_W     = 14;
   localparam int RAMP_W    = 17;
   localparam int POS_W     = 16;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 1;
   localparam int Q16_SHIFT = 16;

   localparam logic [RAMP_W-1:0] Q16_ONE    = 17'h10000;
   localparam logic [RAMP_W-1:0] RAMP_RESET = 17'd256;
   localparam logic [POS_W-1:0]  POS_MAX    = 16'hFFFF;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_SAMPLES = 1'b0,
      CSR_RAMP_STEP     = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_RD_NEW,
      ST_RD_OLD,
      ST_MULT,
      ST_MIX
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic write;
      logic rd_new;
      logic rd_old;
      logic mult;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic wp_last;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/adlc_datapath.sv -----
// Datapath: delay memory, configuration registers, tap addressing and crossfade mix.
`default_nettype none

module adlc_datapath #(
   parameter int DELAY_DEPTH = adlc_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = adlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [adlc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [adlc_pkg::CSR_W-1:0]           csr_write_data,
   input  logic signed [SAMPLE_BITS-1:0]        sample_in,
   input  logic                                 last_in_block,
   input  adlc_pkg::cmd_type                    cmd,
   output adlc_pkg::status_type                 status,
   output logic signed [SAMPLE_BITS-1:0]        sample_out
);

   localparam int ADDR_W    = $clog2(DELAY_DEPTH);
   localparam int DLY_W     = adlc_pkg::DLY_W;
   localparam int RAMP_W    = adlc_pkg::RAMP_W;
   localparam int POS_W     = adlc_pkg::POS_W;
   localparam int WRAW_W    = POS_W + RAMP_W;
   localparam int PROD_W    = SAMPLE_BITS + RAMP_W + 2;
   // Number of compare-and-subtract steps that bring a delay below the depth.
   localparam int RED_STEPS = $clog2(((2 ** DLY_W) - 1) / DELAY_DEPTH + 1);
   localparam int RED_HI    = RED_STEPS / 2;

   // Configuration and persistent state.
   logic [DLY_W-1:0]  delay_ff, delay_in;
   logic [RAMP_W-1:0] ramp_ff, ramp_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [DLY_W-1:0]  prev_ff, prev_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   // Per-item working registers.
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          last_ff;
   logic                          same_ff;
   logic [WRAW_W-1:0]             wraw_ff;
   logic [DLY_W-1:0]              dnew_ff, dold_ff;
   logic [ADDR_W-1:0]             addr_new_ff, addr_old_ff;
   logic [RAMP_W-1:0]             weight_ff, weight_in;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic signed [SAMPLE_BITS-1:0] new_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
   logic [ADDR_W-1:0]      mem_addr;
   logic                   mem_we;
   logic [SAMPLE_BITS-1:0] mem_wdata;

   logic [ADDR_W-1:0]             dnew_red, dold_red;
   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [RAMP_W:0]        weight_s;
   logic signed [PROD_W-1:0]      prod;
   logic signed [PROD_W-1:0]      mix_full;

   // Partial modulo by the depth: subtracts depth shifted by k for k in [lo, hi).
   function automatic logic [DLY_W-1:0] reduce_part(input logic [DLY_W-1:0] v,
                                                    input int lo, input int hi);
      logic [DLY_W-1:0] r;
      logic [DLY_W-1:0] sub;
      r = v;
      for (int k = DLY_W - 1; k >= 0; k--) begin
         sub = DLY_W'(DELAY_DEPTH << k);
         if ((k >= lo) && (k < hi) && (r >= sub)) begin
            r = r - sub;
         end
      end
      return r;
   endfunction

   // Circular address of a tap behind the write pointer.
   function automatic logic [ADDR_W-1:0] tap_addr(input logic [ADDR_W-1:0] a_wp,
                                                  input logic [ADDR_W-1:0] a_d);
      logic [ADDR_W-1:0] a;
      a = a_wp - a_d;
      if (a_wp < a_d) begin
         a = a + ADDR_W'(DELAY_DEPTH);
      end
      return a;
   endfunction

   // Configuration writes.
   always_comb begin
      delay_in = delay_ff;
      ramp_in  = ramp_ff;
      if (csr_write_enable) begin
         case (csr_index)
            adlc_pkg::CSR_DELAY_SAMPLES: delay_in = csr_write_data[DLY_W-1:0];
            adlc_pkg::CSR_RAMP_STEP:     ramp_in  = csr_write_data[RAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // wp steps per sweep write or finish; previous delay and block position on finish.
   always_comb begin
      wp_in   = wp_ff;
      prev_in = prev_ff;
      pos_in  = pos_ff;
      if (cmd.clear || cmd.finish) begin
         wp_in = (wp_ff == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (cmd.finish) begin
         if (last_ff) begin
            prev_in = delay_ff;
            pos_in  = '0;
         end else if (pos_ff != adlc_pkg::POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         ramp_ff  <= adlc_pkg::RAMP_RESET;
         wp_ff    <= '0;
         prev_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         delay_ff <= delay_in;
         ramp_ff  <= ramp_in;
         wp_ff    <= wp_in;
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
      end
   end

   assign status.wp_last = (wp_ff == ADDR_W'(DELAY_DEPTH - 1));

   // Finish the delay reduction and saturate the weight; equal delays take the new tap.
   always_comb begin
      dnew_red = ADDR_W'(reduce_part(dnew_ff, 0, RED_HI));
      dold_red = ADDR_W'(reduce_part(dold_ff, 0, RED_HI));
      if (same_ff || (wraw_ff > WRAW_W'(adlc_pkg::Q16_ONE))) begin
         weight_in = adlc_pkg::Q16_ONE;
      end else begin
         weight_in = wraw_ff[RAMP_W-1:0];
      end
   end

   // Weighted difference and final mix, floored by the arithmetic shift.
   always_comb begin
      diff     = (SAMPLE_BITS + 1)'(new_ff) - (SAMPLE_BITS + 1)'(rd_ff);
      weight_s = $signed({1'b0, weight_ff});
      prod     = PROD_W'(diff) * PROD_W'(weight_s);
      mix_full = (prod_ff >>> adlc_pkg::Q16_SHIFT) + PROD_W'(old_ff);
   end

   // Item pipeline registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample_in;
         last_ff   <= last_in_block;
         same_ff   <= (prev_ff == delay_ff);
         wraw_ff   <= WRAW_W'(pos_ff) * WRAW_W'(ramp_ff);
         dnew_ff   <= reduce_part(delay_ff, RED_HI, RED_STEPS);
         dold_ff   <= reduce_part(prev_ff, RED_HI, RED_STEPS);
      end
      if (cmd.write) begin
         addr_new_ff <= tap_addr(wp_ff, dnew_red);
         addr_old_ff <= tap_addr(wp_ff, dold_red);
         weight_ff   <= weight_in;
      end
      if (cmd.rd_old) begin
         new_ff <= rd_ff;
      end
      if (cmd.mult) begin
         prod_ff <= prod;
         old_ff  <= rd_ff;
      end
      if (cmd.finish) begin
         out_ff <= mix_full[SAMPLE_BITS-1:0];
      end
   end

   // Single-port delay memory: one write or one read per cycle.
   always_comb begin
      mem_we    = cmd.clear || cmd.write;
      mem_wdata = cmd.clear ? '0 : sample_ff;
      if (cmd.rd_new) begin
         mem_addr = addr_new_ff;
      end else if (cmd.rd_old) begin
         mem_addr = addr_old_ff;
      end else begin
         mem_addr = wp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   assign sample_out = out_ff;

endmodule

`default_nettype wire

// ----- hdl/adlc_ctrl.sv -----
// Controller: clearing sweep, per-item sequence and result handshake.
`default_nettype none

module adlc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  adlc_pkg::status_type status,
   output adlc_pkg::cmd_type    cmd
);

   adlc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adlc_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register is free when empty or when its transfer completes now.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         adlc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.wp_last) begin
               state_in = adlc_pkg::ST_IDLE;
            end
         end
         adlc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = adlc_pkg::ST_WRITE;
            end
         end
         adlc_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = adlc_pkg::ST_RD_NEW;
         end
         adlc_pkg::ST_RD_NEW: begin
            cmd.rd_new = 1'b1;
            state_in   = adlc_pkg::ST_RD_OLD;
         end
         adlc_pkg::ST_RD_OLD: begin
            cmd.rd_old = 1'b1;
            state_in   = adlc_pkg::ST_MULT;
         end
         adlc_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = adlc_pkg::ST_MIX;
         end
         adlc_pkg::ST_MIX: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = adlc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adlc_pkg::ST_IDLE;
         end
      endcase
   end

   // Result valid is set as a mix lands and cleared by its transfer.
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hdl/audio_delay_line_crossfade_core.sv -----
// Top level of the variable delay line with linear crossfade.
//
// Usage: each transfer on the req_ channel carries one signed sample and a flag
// that marks the last sample of a processing block. Each item yields exactly one
// transfer on the rsp_ channel carrying the delayed, or crossfaded, sample.
// Registers are written through the csr_ port: index 0 is the delay in samples,
// index 1 the Q16 crossfade step. Write them only while no item is in flight.
// Each accepted item steps through the write, new-tap read, old-tap read, multiply
// and mix states, the mix loading the result register, and the next input transfer
// waits for the mix; the single-port delay memory (one write and two reads per item)
// and the multiply and add stages set this sequence. After reset, req_ready stays
// low while the memory is swept to zero; configuration writes are taken during
// the sweep. The result sits in an output register, so a stalled receiver does
// not block the next input transfer; only the following mix waits until that
// register is taken.
`default_nettype none

module audio_delay_line_crossfade_core #(
   parameter int DELAY_DEPTH = adlc_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = adlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_in,
   input  logic                            req_last_in_block,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]   rsp_sample_out,
   input  logic                            csr_write_enable,
   input  logic [adlc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [adlc_pkg::CSR_W-1:0]      csr_write_data
);

   adlc_pkg::cmd_type    cmd;
   adlc_pkg::status_type status;

   // Sequencer.
   adlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Memory and arithmetic.
   adlc_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sample_in        (req_sample_in),
      .last_in_block    (req_last_in_block),
      .cmd              (cmd),
      .status           (status),
      .sample_out       (rsp_sample_out)
   );

endmodule

`default_nettype wire

// ----- hdl/adlc_checker.sv -----
// Port-level checker of the delay line core and its bind to the top level.
`default_nettype none
`include "audio_delay_line_crossfade_core_assert.svh"

module adlc_checker #(
   parameter int SAMPLE_BITS = adlc_pkg::SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   // A stalled result holds its value.
   `ADLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out))

   // The memory sweep after reset keeps the input closed.
   `ADLC_ASSERT_NOW(a_clear_closed, clock, reset, $past(reset), !req_ready)

   // One item at a time: an input transfer closes the input for the next cycle.
   `ADLC_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   // A result never appears in the cycle right after an input transfer.
   `ADLC_ASSERT_NOW(a_no_early_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready))

endmodule

bind audio_delay_line_crossfade_core adlc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_adlc_checker (.*);

`default_nettype wire
